### hw/rtl/sxp_pkg.sv
// ----------------------------------------------------------------------------
// SysEx request frame parser package
// Frame layout codes, size limits and the configuration register indexes.
// ----------------------------------------------------------------------------
package sxp_pkg;

  // Longest frame that is still accepted (8 to 31).
  localparam int unsigned MaxFrameBytes = 16;

  // Byte counter saturates at its all-ones value, above the last byte position of any legal frame.
  localparam int unsigned CntW  = 5;
  localparam int unsigned LenW  = CntW + 1;
  localparam logic [CntW-1:0] CountMax = '1;

  localparam logic [7:0] StartByte      = 8'hF0;
  localparam logic [7:0] EndByte        = 8'hF7;
  localparam logic [6:0] BlockHandshake  = 7'h01;
  localparam logic [6:0] BlockDescriptor = 7'h10;
  localparam logic [6:0] DirRequest      = 7'h00;

  localparam logic [LenW-1:0] MinLen        = LenW'(6);
  localparam logic [LenW-1:0] HandshakeLen  = LenW'(6);
  localparam logic [LenW-1:0] DescriptorLen = LenW'(8);
  localparam logic [LenW-1:0] MaxLen        = LenW'(MaxFrameBytes);

  // Byte positions within a frame.
  localparam logic [CntW-1:0] PosStart  = CntW'(0);
  localparam logic [CntW-1:0] PosManuf  = CntW'(1);
  localparam logic [CntW-1:0] PosDevice = CntW'(2);
  localparam logic [CntW-1:0] PosBlock  = CntW'(3);
  localparam logic [CntW-1:0] PosDir    = CntW'(4);
  localparam logic [CntW-1:0] PosIdxLo  = CntW'(5);
  localparam logic [CntW-1:0] PosIdxHi  = CntW'(6);

  typedef enum logic [0:0] {
    CfgManufacturer = 1'b0,
    CfgDevice       = 1'b1
  } cfg_idx_e;

endpackage

### hw/rtl/sxp_if.sv
// ----------------------------------------------------------------------------
// SysEx request frame parser channels
// Valid/ready channels for incoming frame bytes and outgoing verdicts.
// ----------------------------------------------------------------------------
interface sxp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface sxp_verdict_if;
  logic        valid;
  logic        ready;
  logic        request_valid;
  logic [6:0]  block_code;
  logic [6:0]  direction_code;
  logic        has_index;
  logic [13:0] chunk_number;

  modport source (output valid, output request_valid, output block_code,
                  output direction_code, output has_index, output chunk_number,
                  input ready);
  modport sink   (input valid, input request_valid, input block_code,
                  input direction_code, input has_index, input chunk_number,
                  output ready);
endinterface

### hw/rtl/sysex_request_frame_parser_core.sv
// ----------------------------------------------------------------------------
// SysEx request frame parser core
// Checks a system-exclusive request frame byte by byte and emits one verdict
// per frame on its last byte.
// ----------------------------------------------------------------------------
// Usage:
//   frame_i carries one frame byte per request, with last_byte set on the
//   final byte. Every byte updates the running frame state; a last byte also
//   loads the verdict register, which drives verdict_o. One byte is taken
//   every cycle while the verdict register is empty or being drained.
//   If the receiver stalls verdict_o, the verdict is held and frame_i.ready
//   drops until it is taken; the single result register is the only stage.
//   The manufacturer and device bytes are written through the cfg port; the
//   user must write them only while no frame is in flight, which the block
//   itself does not enforce. Reset clears the frame state, empties the result
//   register and sets the identity bytes to 125 and 0.
//   Rejected frames (bad header, bad end byte, 8-bit inner byte, too short or
//   longer than MaxFrameBytes) give an all-zero verdict.
// ----------------------------------------------------------------------------
module sysex_request_frame_parser_core
  import sxp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sxp_byte_if.sink             frame_i,
  sxp_verdict_if.source        verdict_o,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [6:0]           cfg_data_i
);

  logic [6:0]      manuf_q, dev_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            hdr_q, hdr_d;
  logic            inner_q, inner_d;
  logic [6:0]      block_q, block_d;
  logic [6:0]      dir_q, dir_d;
  logic [6:0]      idx_lo_q, idx_lo_d;
  logic [6:0]      idx_hi_q, idx_hi_d;

  logic            out_valid_q;
  logic            res_req_q, res_req_d;
  logic [6:0]      res_block_q, res_block_d;
  logic [6:0]      res_dir_q, res_dir_d;
  logic            res_idx_q, res_idx_d;
  logic [13:0]     res_chunk_q, res_chunk_d;

  logic            accept;
  logic            last;
  logic [7:0]      b;
  logic [LenW-1:0] len;
  logic            good;

  assign frame_i.ready = !out_valid_q || verdict_o.ready;
  assign accept        = frame_i.valid && frame_i.ready;
  assign b             = frame_i.frame_byte;
  assign last          = frame_i.last_byte;
  assign len           = LenW'(cnt_q) + LenW'(1);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      manuf_q <= 7'd125;
      dev_q   <= 7'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgManufacturer: manuf_q <= cfg_data_i;
        CfgDevice:       dev_q   <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // Running frame state. Header and capture checks only matter below
  // position seven, so the stored flags suffice when the last byte arrives.
  always_comb begin
    hdr_d    = hdr_q;
    inner_d  = inner_q;
    block_d  = block_q;
    dir_d    = dir_q;
    idx_lo_d = idx_lo_q;
    idx_hi_d = idx_hi_q;
    cnt_d    = (cnt_q == CountMax) ? cnt_q : cnt_q + CntW'(1);

    if (cnt_q == PosStart && b != StartByte)        hdr_d = 1'b0;
    if (cnt_q == PosManuf && b != {1'b0, manuf_q})  hdr_d = 1'b0;
    if (cnt_q == PosDevice && b != {1'b0, dev_q})   hdr_d = 1'b0;
    if (cnt_q == PosBlock) block_d  = b[6:0];
    if (cnt_q == PosDir)   dir_d    = b[6:0];
    if (cnt_q == PosIdxLo) idx_lo_d = b[6:0];
    if (cnt_q == PosIdxHi) idx_hi_d = b[6:0];
    if (cnt_q != PosStart && !last && b[7]) inner_d = 1'b0;

    if (last) begin
      cnt_d    = '0;
      hdr_d    = 1'b1;
      inner_d  = 1'b1;
      block_d  = '0;
      dir_d    = '0;
      idx_lo_d = '0;
      idx_hi_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      hdr_q    <= 1'b1;
      inner_q  <= 1'b1;
      block_q  <= '0;
      dir_q    <= '0;
      idx_lo_q <= '0;
      idx_hi_q <= '0;
    end else if (accept) begin
      cnt_q    <= cnt_d;
      hdr_q    <= hdr_d;
      inner_q  <= inner_d;
      block_q  <= block_d;
      dir_q    <= dir_d;
      idx_lo_q <= idx_lo_d;
      idx_hi_q <= idx_hi_d;
    end
  end

  // Verdict for a frame ending with the current byte.
  always_comb begin
    good = hdr_q && inner_q && (b == EndByte) && (len >= MinLen) && (len <= MaxLen);
    res_req_d   = 1'b0;
    res_idx_d   = 1'b0;
    res_chunk_d = '0;
    res_block_d = '0;
    res_dir_d   = '0;
    if (good) begin
      res_block_d = block_q;
      res_dir_d   = dir_q;
      if (dir_q == DirRequest) begin
        if (block_q == BlockHandshake && len == HandshakeLen) begin
          res_req_d = 1'b1;
        end else if (block_q == BlockDescriptor && len == DescriptorLen) begin
          res_req_d   = 1'b1;
          res_idx_d   = 1'b1;
          res_chunk_d = {idx_hi_q, idx_lo_q};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && last) begin
      out_valid_q <= 1'b1;
    end else if (verdict_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      res_req_q   <= res_req_d;
      res_block_q <= res_block_d;
      res_dir_q   <= res_dir_d;
      res_idx_q   <= res_idx_d;
      res_chunk_q <= res_chunk_d;
    end
  end

  assign verdict_o.valid          = out_valid_q;
  assign verdict_o.request_valid  = res_req_q;
  assign verdict_o.block_code     = res_block_q;
  assign verdict_o.direction_code = res_dir_q;
  assign verdict_o.has_index      = res_idx_q;
  assign verdict_o.chunk_number   = res_chunk_q;

  // A last byte always produces a verdict in the next cycle.
  a_last_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> out_valid_q)
    else $error("last byte did not produce a verdict");

  // Frame state returns to its idle values after each verdict.
  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> cnt_q == '0 && hdr_q && inner_q)
    else $error("frame state not cleared after last byte");

  // An answerable request always has the request direction.
  a_valid_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_req_q |-> res_dir_q == DirRequest)
    else $error("answerable verdict with non-request direction");

  // A chunk index only comes with a valid descriptor request.
  a_index_descr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_idx_q |-> res_req_q && res_block_q == BlockDescriptor)
    else $error("chunk index without a descriptor request");

  // No new byte is taken while a verdict is stalled.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !verdict_o.ready |-> !accept)
    else $error("byte accepted while verdict stalled");

endmodule

### dv/sysex_request_frame_parser_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SysEx request frame parser core testbench
// Sends directed and random request frames one byte per request and checks
// every verdict against a cycle-free model of the frame checks. Random idling
// on both channels and identity register changes between phases.
// ----------------------------------------------------------------------------
module sysex_request_frame_parser_core_test;
  import sxp_pkg::*;

  typedef struct packed {
    logic        request_valid;
    logic [6:0]  block_code;
    logic [6:0]  direction_code;
    logic        has_index;
    logic [13:0] chunk_number;
  } verdict_t;

  // Tracks the frame in flight and holds the verdicts still to be taken.
  class verdict_book;
    logic [6:0]  manuf_id;
    logic [6:0]  device_id;
    logic [CntW-1:0] count;
    logic        header_ok;
    logic        inner_ok;
    logic [6:0]  blk_byte;
    logic [6:0]  dir_byte;
    logic [6:0]  idx_lo;
    logic [6:0]  idx_hi;
    verdict_t    awaited_verdicts[$];
    int unsigned errors;

    function new();
      manuf_id  = 7'd125;
      device_id = 7'd0;
      errors    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      count     = '0;
      header_ok = 1'b1;
      inner_ok  = 1'b1;
      blk_byte  = '0;
      dir_byte  = '0;
      idx_lo    = '0;
      idx_hi    = '0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [6:0] value);
      if (idx == CfgManufacturer) begin
        manuf_id = value;
      end else begin
        device_id = value;
      end
    endfunction

    function int unsigned pending();
      return awaited_verdicts.size();
    endfunction

    function void note_request(logic [7:0] data, logic last);
      logic [CntW-1:0] pos;
      int unsigned     len;
      logic            good;
      verdict_t        v;
      pos = count;
      if (pos == PosStart && data != StartByte) header_ok = 1'b0;
      if (pos == PosManuf && data != {1'b0, manuf_id}) header_ok = 1'b0;
      if (pos == PosDevice && data != {1'b0, device_id}) header_ok = 1'b0;
      if (pos == PosBlock) blk_byte = data[6:0];
      if (pos == PosDir) dir_byte = data[6:0];
      if (pos == PosIdxLo) idx_lo = data[6:0];
      if (pos == PosIdxHi) idx_hi = data[6:0];
      // The last byte is the end marker, so only inner bytes must be 7-bit.
      if (pos != PosStart && !last && data[7]) inner_ok = 1'b0;
      if (count != CountMax) count = count + 1'b1;
      if (!last) return;

      len  = int'(pos) + 1;
      good = header_ok && inner_ok && data == EndByte &&
             len >= int'(MinLen) && len <= MaxFrameBytes;
      v = '0;
      if (good) begin
        v.block_code     = blk_byte;
        v.direction_code = dir_byte;
        if (dir_byte == DirRequest) begin
          if (blk_byte == BlockHandshake && len == int'(HandshakeLen)) begin
            v.request_valid = 1'b1;
          end else if (blk_byte == BlockDescriptor && len == int'(DescriptorLen)) begin
            v.request_valid = 1'b1;
            v.has_index     = 1'b1;
            v.chunk_number  = {idx_hi, idx_lo};
          end
        end
      end
      awaited_verdicts = {awaited_verdicts, v};
      clear_frame();
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: verdict %s mismatch: expected 0x%0h, actual 0x%0h",
                 $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (awaited_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict 0x%0h", $time, got);
        errors++;
        return;
      end
      want = awaited_verdicts.pop_front();
      compare_field("request_valid", want.request_valid, got.request_valid);
      compare_field("block_code", want.block_code, got.block_code);
      compare_field("direction_code", want.direction_code, got.direction_code);
      compare_field("has_index", want.has_index, got.has_index);
      compare_field("chunk_number", want.chunk_number, got.chunk_number);
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [6:0] cfg_data_i;

  sxp_byte_if    frame_if ();
  sxp_verdict_if verdict_if ();

  sysex_request_frame_parser_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .frame_i    (frame_if),
    .verdict_o  (verdict_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  verdict_book book;
  logic [7:0]  frame_buf[$];
  logic [6:0]  cur_manuf = 7'd125;
  logic [6:0]  cur_device = 7'd0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    verdict_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      verdict_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    verdict_t got;
    if (rst_ni && verdict_if.valid && verdict_if.ready) begin
      got.request_valid  = verdict_if.request_valid;
      got.block_code     = verdict_if.block_code;
      got.direction_code = verdict_if.direction_code;
      got.has_index      = verdict_if.has_index;
      got.chunk_number   = verdict_if.chunk_number;
      book.check_verdict(got);
    end
  end

  // Lays out a frame of the given length; positions past the index bytes
  // are 7-bit filler and the final position is the end marker.
  function automatic void build_frame(int unsigned len, logic [6:0] blk, logic [6:0] dir,
                                      logic [13:0] chunk);
    logic [7:0] head[7];
    logic [7:0] fill;
    head = '{StartByte, {1'b0, cur_manuf}, {1'b0, cur_device}, {1'b0, blk},
             {1'b0, dir}, {1'b0, chunk[6:0]}, {1'b0, chunk[13:7]}};
    frame_buf.delete();
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) begin
        frame_buf = {frame_buf, EndByte};
      end else if (i < 7) begin
        frame_buf = {frame_buf, head[i]};
      end else begin
        fill      = {1'b0, 7'($urandom_range(0, 127))};
        frame_buf = {frame_buf, fill};
      end
    end
  endfunction

  // Enters and leaves at a falling edge.
  task automatic push_byte(logic [7:0] data, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      frame_if.valid = 1'b0;
      @(negedge clk_i);
    end
    frame_if.valid      = 1'b1;
    frame_if.frame_byte = data;
    frame_if.last_byte  = last;
    do @(posedge clk_i); while (!frame_if.ready);
    book.note_request(data, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      push_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  task automatic wait_idle();
    frame_if.valid = 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [6:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    book.set_register(idx, value);
    if (idx == CfgManufacturer) begin
      cur_manuf = value;
    end else begin
      cur_device = value;
    end
  endtask

  task automatic send_random_frame();
    int unsigned r;
    int unsigned len;
    int unsigned pos;
    logic [6:0]  blk;
    logic [6:0]  dir;
    logic [13:0] chunk;
    r     = $urandom_range(0, 99);
    blk   = BlockHandshake;
    dir   = DirRequest;
    chunk = 14'($urandom_range(0, 16383));
    len   = 6;
    if (r < 25) begin
      len = 6;
    end else if (r < 50) begin
      blk = BlockDescriptor;
      len = 8;
      if ($urandom_range(0, 3) == 0) chunk = $urandom_range(0, 1) ? '1 : '0;
    end else if (r < 90) begin
      case ($urandom_range(0, 2))
        0: begin
          blk = BlockHandshake;
        end
        1: begin
          blk = BlockDescriptor;
        end
        default: begin
          blk = 7'($urandom_range(0, 127));
        end
      endcase
      if ($urandom_range(0, 1)) dir = 7'($urandom_range(0, 127));
      len = $urandom_range(4, MaxFrameBytes + 2);
    end

    if (r >= 90) begin
      // Raw noise, long enough at times to saturate the byte counter.
      frame_buf.delete();
      len = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
      if ($urandom_range(0, 1)) frame_buf[len - 1] = EndByte;
    end else begin
      build_frame(len, blk, dir, chunk);
      if (r >= 65 && r < 80) begin
        pos = $urandom_range(0, len - 1);
        frame_buf[pos] = 8'($urandom_range(0, 255));
      end else if (r >= 80 && len > 2) begin
        pos = $urandom_range(1, len - 2);
        frame_buf[pos][7] = 1'b1;
      end
    end
    send_frame();
  endtask

  initial begin
    int unsigned send_plan[4];
    int unsigned recv_plan[4];
    int unsigned target;
    logic        paused;
    send_plan = '{0, 84, 0, 6};
    recv_plan = '{0, 0, 84, 6};

    book                = new();
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CfgManufacturer;
    cfg_data_i          = '0;
    frame_if.valid      = 1'b0;
    frame_if.frame_byte = '0;
    frame_if.last_byte  = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed frames under the reset identity bytes.
    build_frame(6, BlockHandshake, DirRequest, '0);
    send_frame();
    build_frame(8, BlockDescriptor, DirRequest, '0);
    send_frame();
    build_frame(8, BlockDescriptor, DirRequest, '1);
    send_frame();
    build_frame(6, BlockDescriptor, DirRequest, '0);
    send_frame();
    build_frame(8, BlockHandshake, DirRequest, 14'h1555);
    send_frame();
    build_frame(6, BlockHandshake, 7'h7F, '0);
    send_frame();
    build_frame(6, 7'h7F, DirRequest, '0);
    send_frame();
    build_frame(5, BlockHandshake, DirRequest, '0);
    send_frame();
    build_frame(1, BlockHandshake, DirRequest, '0);
    send_frame();
    build_frame(MaxFrameBytes, BlockDescriptor, DirRequest, 14'h2AAA);
    send_frame();
    build_frame(MaxFrameBytes + 1, BlockHandshake, DirRequest, '0);
    send_frame();
    build_frame(40, BlockHandshake, DirRequest, '0);
    send_frame();
    build_frame(6, BlockHandshake, DirRequest, '0);
    frame_buf[0] = 8'h00;
    send_frame();
    build_frame(6, BlockHandshake, DirRequest, '0);
    frame_buf[5] = 8'hFF;
    send_frame();
    build_frame(8, BlockDescriptor, DirRequest, '0);
    frame_buf[5] = 8'h81;
    send_frame();
    build_frame(6, BlockHandshake, DirRequest, '0);
    frame_buf[1] = frame_buf[1] ^ 8'h01;
    send_frame();
    build_frame(6, BlockHandshake, DirRequest, '0);
    frame_buf[2] = 8'h80;
    send_frame();

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_register(CfgManufacturer, 7'd0);
          write_register(CfgDevice, 7'd127);
        end
        1: begin
          write_register(CfgManufacturer, 7'd127);
          write_register(CfgDevice, 7'd0);
        end
        default: begin
          write_register(CfgManufacturer, 7'($urandom_range(0, 127)));
          write_register(CfgDevice, 7'($urandom_range(0, 127)));
        end
      endcase
      send_idle_pct  = send_plan[p];
      recv_stall_pct = recv_plan[p];
      target         = bytes_sent + 70;
      paused         = 1'b0;
      while (bytes_sent < target) begin
        // Halfway through, hold off until the verdict channel is empty.
        if (!paused && bytes_sent + 35 >= target) begin
          wait_idle();
          paused = 1'b1;
        end
        send_random_frame();
      end
    end

    frame_if.valid = 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/sxp_pkg.sv
hw/rtl/sxp_if.sv
hw/rtl/sysex_request_frame_parser_core.sv
dv/sysex_request_frame_parser_core_test.sv
